@@ hdl/rn2a_pkg.sv @@
package rn2a_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_SLOTS = 12;

    localparam int IN_BITS   = 32;
    localparam int CHAR_BITS = 7;
    localparam int SEL_BITS  = 2;

    localparam int OCT_FULL  = VALUE_BITS / 3 + 1;
    localparam int HEX_FULL  = (VALUE_BITS + 3) / 4;
    localparam int DEC_FULL  = 10;
    localparam int OCT_LIMIT = (OCT_FULL > DIGIT_SLOTS) ? DIGIT_SLOTS : OCT_FULL;
    localparam int HEX_LIMIT = (HEX_FULL > DIGIT_SLOTS) ? DIGIT_SLOTS : HEX_FULL;
    localparam int DEC_LIMIT = (DEC_FULL > DIGIT_SLOTS) ? DIGIT_SLOTS : DEC_FULL;

    localparam int CNT_BITS  = $clog2(DIGIT_SLOTS + 1);
    localparam int SLOT_BITS = $clog2(DIGIT_SLOTS);
    localparam int ITER_BITS = $clog2(VALUE_BITS + 1);
    localparam int BUF_BITS  = DIGIT_SLOTS * 4;

    localparam logic [SEL_BITS-1:0] RADIX_OCT = 2'd0;
    localparam logic [SEL_BITS-1:0] RADIX_DEC = 2'd1;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h37;

    typedef logic [CNT_BITS-1:0] t_count;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'd0, d};
        end else begin
            c = CHAR_ALPHA + {3'd0, d};
        end
        return c;
    endfunction

endpackage

@@ hdl/radix_number_to_ascii.sv @@
// Binary to ASCII converter for octal, decimal and hexadecimal output.
// Command channel: present i_value and i_radix_select with start high while
// busy is low; the item is taken on that clock edge and busy rises on the
// next cycle, staying high until the last character has been sent.
// Result channel: each character appears on o_ascii_char for one cycle with
// o_valid high; o_last_char marks the final character of the number. The
// receiver has no way to stall, so every beat must be taken as it comes.
// Timing: octal and hex load their digits straight from the value, decimal
// runs a shift-and-add-3 loop over the value, one bit a cycle. Leading
// zeros are then dropped one per cycle (for every decimal value, but only
// for non-negative octal and hex values), and characters leave one per
// cycle. The last character is on the ports in the cycle in which busy
// falls, and the next item can be taken at the end of that cycle. The
// decimal bit loop sets the worst case.
// Reset (synchronous, active low) returns the sequencer to idle, drops busy
// and o_valid; a number being printed is abandoned.
module radix_number_to_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rn2a_pkg::IN_BITS-1:0]   i_value,
    input  logic [rn2a_pkg::SEL_BITS-1:0]      i_radix_select,
    output logic                              o_valid,
    output logic [rn2a_pkg::CHAR_BITS-1:0]     o_ascii_char,
    output logic                              o_last_char
);
    import rn2a_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_STRIP = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int OCT_EXT = 3 * DIGIT_SLOTS;
    localparam int HEX_EXT = 4 * DIGIT_SLOTS;

    logic [2:0]            r_state, n_state;
    logic [BUF_BITS-1:0]   r_buf, n_buf;
    logic [VALUE_BITS-1:0] r_work, n_work;
    t_count                r_cnt, n_cnt;
    logic [ITER_BITS-1:0]  r_iter, n_iter;
    logic                  r_neg, n_neg;
    logic                  r_valid, n_valid;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [OCT_EXT-1:0]    oct_ext;
    logic [HEX_EXT-1:0]    hex_ext;
    logic [BUF_BITS-1:0]   oct_buf;
    logic [BUF_BITS-1:0]   hex_buf;
    logic [BUF_BITS-1:0]   adj_buf;
    logic [SLOT_BITS-1:0]  top_slot;
    logic [3:0]            top_digit;
    t_count                next_cnt;

    assign raw     = i_value[VALUE_BITS-1:0];
    assign neg     = raw[VALUE_BITS-1];
    assign mag     = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
    assign oct_ext = {{(OCT_EXT-VALUE_BITS){neg}}, raw};
    assign hex_ext = {{(HEX_EXT-VALUE_BITS){neg}}, raw};

    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            logic [3:0] nib;
            nib = r_buf[i*4 +: 4];
            oct_buf[i*4 +: 4] = {1'b0, oct_ext[i*3 +: 3]};
            hex_buf[i*4 +: 4] = hex_ext[i*4 +: 4];
            adj_buf[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    assign next_cnt  = r_cnt - t_count'(1);
    assign top_slot  = next_cnt[SLOT_BITS-1:0];
    assign top_digit = r_buf[top_slot*4 +: 4];

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_work  = r_work;
        n_cnt   = r_cnt;
        n_iter  = r_iter;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_radix_select == RADIX_DEC) begin
                        n_buf   = '0;
                        n_work  = mag;
                        n_iter  = ITER_BITS'(VALUE_BITS);
                        n_cnt   = t_count'(DEC_LIMIT);
                        n_neg   = neg;
                        n_state = S_CONV;
                    end else begin
                        // two's-complement form keeps all its digits
                        n_neg   = 1'b0;
                        n_state = neg ? S_EMIT : S_STRIP;
                        if (i_radix_select == RADIX_OCT) begin
                            n_buf = oct_buf;
                            n_cnt = t_count'(OCT_LIMIT);
                        end else begin
                            n_buf = hex_buf;
                            n_cnt = t_count'(HEX_LIMIT);
                        end
                    end
                end
            end
            S_CONV: begin
                // add 3 to every digit of 5 or more, then shift in the next bit
                n_buf  = {adj_buf[BUF_BITS-2:0], r_work[VALUE_BITS-1]};
                n_work = {r_work[VALUE_BITS-2:0], 1'b0};
                n_iter = r_iter - ITER_BITS'(1);
                if (r_iter == ITER_BITS'(1)) begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (r_cnt > t_count'(1) && top_digit == 4'd0) begin
                    n_cnt = next_cnt;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = CHAR_MINUS;
                n_last  = 1'b0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_char  = digit_char(top_digit);
                n_last  = (r_cnt == t_count'(1));
                n_cnt   = next_cnt;
                if (r_cnt == t_count'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_iter  <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_iter  <= n_iter;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_work <= n_work;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule
